// ===== rtl/crcfp_pkg.sv =====
// Shared types, codes and the CRC-8 byte update for the frame receive parser.
package crcfp_pkg;

	// Parser phase codes.
	localparam logic [2:0] PH_SYNC1   = 3'd0;
	localparam logic [2:0] PH_SYNC2   = 3'd1;
	localparam logic [2:0] PH_ID      = 3'd2;
	localparam logic [2:0] PH_LEN     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CRC     = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_GOOD  = 2'd1;
	localparam logic [1:0] KIND_BAD   = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// Input word modes.
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
	localparam logic [1:0] CFG_MAX_PAYLOAD   = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

	// CRC-8 constants.
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;

	localparam logic [15:0] IDLE_MAX = 16'hFFFF;

	// Configuration register set.
	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [7:0]  max_payload;
		logic [15:0] timeout_ticks;
	} cfg_regs_t;

	// Parser state carried from one word to the next.
	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  crc;
		logic [7:0]  held_id;
		logic [7:0]  held_length;
		logic [7:0]  payload_count;
		logic [15:0] idle_count;
	} parser_state_t;

	// One result word with its valid flag.
	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  frame_id;
		logic [7:0]  frame_length;
	} result_t;

	// One byte of an MSB-first CRC-8 with no reflection.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crcfp_cfg.sv =====
// Configuration registers of the frame receive parser.
module crcfp_cfg
	import crcfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_regs_t   cfg
);

	cfg_regs_t cfg_q;

	// Register writes, one index per write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first    <= 8'hAA;
			cfg_q.sync_second   <= 8'h55;
			cfg_q.max_payload   <= 8'hFF;
			cfg_q.timeout_ticks <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:    cfg_q.sync_first    <= cfg_data[7:0];
				CFG_SYNC_SECOND:   cfg_q.sync_second   <= cfg_data[7:0];
				CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data[7:0];
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/crcfp_step.sv =====
// Next-state and result logic for one input word of the frame parser.
module crcfp_step
	import crcfp_pkg::*;
(
	input  cfg_regs_t     cfg,
	input  parser_state_t cur,
	input  logic          mode,
	input  logic [7:0]    rx_byte,
	output parser_state_t nxt,
	output result_t       res
);

	logic [15:0] idle_inc;
	logic [7:0]  count_inc;
	logic [7:0]  crc_in;
	logic [7:0]  crc_out;

	// Saturating idle counter and payload count increment.
	assign idle_inc  = (cur.idle_count == IDLE_MAX) ? cur.idle_count : cur.idle_count + 16'd1;
	assign count_inc = cur.payload_count + 8'd1;

	// The id byte starts a fresh CRC, later bytes continue it.
	assign crc_in  = (cur.phase == PH_ID) ? CRC_INIT : cur.crc;
	assign crc_out = crc8_update(crc_in, rx_byte);

	// Phase update and result selection.
	always_comb begin
		nxt              = cur;
		res.valid        = 1'b0;
		res.kind         = KIND_DATA;
		res.data_byte    = 8'd0;
		res.byte_index   = 8'd0;
		res.frame_id     = cur.held_id;
		res.frame_length = cur.held_length;
		if (mode == MODE_TICK) begin
			if (cur.phase == PH_SYNC1 || cur.phase > PH_CRC) begin
				nxt.phase = PH_SYNC1;
			end else begin
				nxt.idle_count = idle_inc;
				if (idle_inc > cfg.timeout_ticks) begin
					nxt.phase         = PH_SYNC1;
					nxt.payload_count = 8'd0;
					nxt.idle_count    = 16'd0;
					nxt.crc           = CRC_INIT;
					if (cur.payload_count != 8'd0) begin
						res.valid = 1'b1;
						res.kind  = KIND_ABORT;
					end
				end
			end
		end else begin
			nxt.idle_count = 16'd0;
			unique case (cur.phase)
				PH_SYNC2: begin
					if (rx_byte == cfg.sync_second) begin
						nxt.phase = PH_ID;
					end else if (rx_byte != cfg.sync_first) begin
						nxt.phase = PH_SYNC1;
					end
				end
				PH_ID: begin
					nxt.held_id = rx_byte;
					nxt.crc     = crc_out;
					nxt.phase   = PH_LEN;
				end
				PH_LEN: begin
					if (rx_byte > cfg.max_payload) begin
						nxt.phase         = PH_SYNC1;
						nxt.payload_count = 8'd0;
						nxt.crc           = CRC_INIT;
					end else begin
						nxt.held_length   = rx_byte;
						nxt.crc           = crc_out;
						nxt.payload_count = 8'd0;
						nxt.phase         = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					nxt.crc           = crc_out;
					nxt.payload_count = count_inc;
					if (count_inc >= cur.held_length) begin
						nxt.phase = PH_CRC;
					end
					res.valid      = 1'b1;
					res.kind       = KIND_DATA;
					res.data_byte  = rx_byte;
					res.byte_index = cur.payload_count;
				end
				PH_CRC: begin
					res.valid         = 1'b1;
					res.kind          = (rx_byte == cur.crc) ? KIND_GOOD : KIND_BAD;
					nxt.phase         = PH_SYNC1;
					nxt.payload_count = 8'd0;
					nxt.crc           = CRC_INIT;
				end
				default: begin
					nxt.phase = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/crc8_frame_receive_parser.sv =====
// Top level of the CRC-8 frame receive parser: input register, parser state, result register.
//
//   Channel | Direction | Handshake          | Payload
//   input   | in        | in_valid/in_stall  | mode, rx_byte
//   result  | out       | out_valid/out_stall| kind, data_byte, byte_index, frame_id, frame_length
//   config  | in        | cfg_we             | cfg_index, cfg_data
//
// One word is accepted every cycle while in_stall is low.
// The input register feeds the parser step logic, which updates the state and the result
// register in the same cycle. Reset clears the input and result valid flags and the parser
// state, and loads the configuration defaults. While a result waits under out_stall, the word
// in the input register holds and in_stall rises until the result register frees up.
module crc8_frame_receive_parser
	import crcfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  byte_index,
	output logic [7:0]  frame_id,
	output logic [7:0]  frame_length,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_regs_t     cfg;
	parser_state_t state_q;
	parser_state_t state_nxt;
	result_t       res;

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_byte_q;
	logic [7:0] byte_index_q;
	logic [7:0] frame_id_q;
	logic [7:0] frame_length_q;
	logic       out_free;
	logic       step_go;
	logic       in_take;

	crcfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crcfp_step u_step (
		.cfg     (cfg),
		.cur     (state_q),
		.mode    (mode_s1),
		.rx_byte (byte_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	// Handshake control: the staged word advances whenever the result register can load.
	assign out_free = !out_valid_q || !out_stall;
	assign step_go  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	// Parser state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_SYNC1;
			state_q.crc           <= CRC_INIT;
			state_q.held_id       <= 8'd0;
			state_q.held_length   <= 8'd0;
			state_q.payload_count <= 8'd0;
			state_q.idle_count    <= 16'd0;
		end else if (step_go) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step_go && res.valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (step_go && res.valid) begin
			kind_q         <= res.kind;
			data_byte_q    <= res.data_byte;
			byte_index_q   <= res.byte_index;
			frame_id_q     <= res.frame_id;
			frame_length_q <= res.frame_length;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_byte_q;
	assign byte_index   = byte_index_q;
	assign frame_id     = frame_id_q;
	assign frame_length = frame_length_q;

endmodule
